>>> rtl/ir_start_module_sumo_controller_top_macros.svh
// Assertion macros used by the top RTL file of the start module controller.
`ifndef IR_START_MODULE_SUMO_CONTROLLER_TOP_MACROS_SVH
`define IR_START_MODULE_SUMO_CONTROLLER_TOP_MACROS_SVH

// Clocked check, ignored while reset is asserted.
`define IRSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that the consequence holds in the cycle after the trigger.
`define IRSC_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/irsc_pkg.sv
// Types, constants and helper functions for the start module controller.
`default_nettype none

package irsc_pkg;

	// Request codes
	localparam logic [1:0] REQ_EDGE = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_CTRL = 2'd2;

	// Run modes
	localparam logic [1:0] MODE_WAIT    = 2'd0;
	localparam logic [1:0] MODE_FIGHT   = 2'd1;
	localparam logic [1:0] MODE_STOPPED = 2'd2;

	// Blink requests
	localparam logic [1:0] BLINK_NONE = 2'd0;
	localparam logic [1:0] BLINK_FAST = 2'd1;
	localparam logic [1:0] BLINK_SLOW = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EARLY_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROG_ADDR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SS_ADDR     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_SCALE = 3'd4;
	localparam int unsigned CFG_DATA_W = 16;

	// Motor speeds in percent
	localparam logic [6:0] SPD_ZERO = 7'd0;
	localparam logic [6:0] SPD_40   = 7'd40;
	localparam logic [6:0] SPD_60   = 7'd60;
	localparam logic [6:0] SPD_80   = 7'd80;
	localparam logic [6:0] SPD_FULL = 7'd100;

	// Eye bit positions
	localparam int unsigned EYE_SL = 0;
	localparam int unsigned EYE_FL = 1;
	localparam int unsigned EYE_C  = 2;
	localparam int unsigned EYE_FR = 3;
	localparam int unsigned EYE_SR = 4;

	typedef struct packed {
		logic [15:0] bit_period;
		logic [15:0] early_limit;
		logic [4:0]  prog_addr;
		logic [4:0]  ss_addr;
		logic [9:0]  motor_scale;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		bit_period:  16'd40421,
		early_limit: 16'd10042,
		prog_addr:   5'h0B,
		ss_addr:     5'h07,
		motor_scale: 10'd640
	};

	typedef struct packed {
		logic [1:0] req_type;
		logic       ir_level;
		logic       kill_pin;
		logic [4:0] eyes;
	} item_t;

	typedef struct packed {
		logic [13:0] frame;
		logic        armed;
		logic [15:0] window;
		logic [1:0]  mode;
		logic [5:0]  arena;
		logic        turn_left;
		logic [6:0]  held_l;
		logic [6:0]  held_r;
	} state_t;

	localparam state_t STATE_RESET = '{
		frame:     14'd0,
		armed:     1'b1,
		window:    16'd0,
		mode:      MODE_WAIT,
		arena:     6'd0,
		turn_left: 1'b0,
		held_l:    SPD_ZERO,
		held_r:    SPD_ZERO
	};

	typedef struct packed {
		logic [1:0] blink;
		logic       persist;
	} step_flags_t;

	// Result of one beat before duty scaling
	typedef struct packed {
		logic [6:0]  spd_l;
		logic [6:0]  spd_r;
		logic [1:0]  mode;
		logic [5:0]  arena;
		logic [1:0]  blink;
		logic        persist;
		logic [13:0] frame;
	} stage1_t;

	// Speed times scale, saturated to 16 bits
	function automatic logic [15:0] duty_of(input logic [6:0] spd, input logic [9:0] scale);
		logic [16:0] prod;
		prod = 17'(spd) * 17'(scale);
		return prod[16] ? 16'hFFFF : prod[15:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/irsc_item_if.sv
// Input channel: one request beat per handshake.
`default_nettype none

interface irsc_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       ir_level;
	logic       kill_pin;
	logic [4:0] eyes;

	modport source(output valid, output req_type, output ir_level, output kill_pin,
		output eyes, input ready);
	modport sink(input valid, input req_type, input ir_level, input kill_pin,
		input eyes, output ready);
endinterface

`default_nettype wire

>>> rtl/irsc_result_if.sv
// Output channel: one result beat per handshake.
`default_nettype none

interface irsc_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] left_duty;
	logic [15:0] right_duty;
	logic [1:0]  mode;
	logic [5:0]  arena_code;
	logic [1:0]  blink_request;
	logic        persist_write;
	logic [13:0] frame_bits;

	modport source(output valid, output left_duty, output right_duty, output mode,
		output arena_code, output blink_request, output persist_write,
		output frame_bits, input ready);
	modport sink(input valid, input left_duty, input right_duty, input mode,
		input arena_code, input blink_request, input persist_write,
		input frame_bits, output ready);
endinterface

`default_nettype wire

>>> rtl/irsc_step.sv
// Next-state logic for one request: RC5 sampling, frame decode and motor choice.
`default_nettype none

module irsc_step (
	input  irsc_pkg::item_t       item,
	input  irsc_pkg::state_t      st,
	input  irsc_pkg::cfg_t        cfg,
	output irsc_pkg::state_t      st_next,
	output irsc_pkg::step_flags_t flags
);

	logic [13:0] frame_e;
	logic [4:0]  addr;
	logic [5:0]  cmd;
	logic        sl, fl, ctr, fr, sr;

	assign addr = frame_e[10:6];
	assign cmd  = frame_e[5:0];
	assign sl   = item.eyes[irsc_pkg::EYE_SL];
	assign fl   = item.eyes[irsc_pkg::EYE_FL];
	assign ctr  = item.eyes[irsc_pkg::EYE_C];
	assign fr   = item.eyes[irsc_pkg::EYE_FR];
	assign sr   = item.eyes[irsc_pkg::EYE_SR];

	// Frame after sampling an edge
	always_comb begin
		frame_e = st.frame;
		if (st.armed) begin
			frame_e = {st.frame[12:0], ~item.ir_level};
		end else if (st.window < cfg.early_limit) begin
			frame_e = '0;
		end
	end

	always_comb begin
		st_next = st;
		flags   = '{blink: irsc_pkg::BLINK_NONE, persist: 1'b0};
		case (item.req_type)
			irsc_pkg::REQ_EDGE: begin
				st_next.frame = frame_e;
				if (st.armed) begin
					st_next.armed  = 1'b0;
					st_next.window = '0;
				end
				// Decode a frame with both start bits set
				if (st.mode != irsc_pkg::MODE_STOPPED && frame_e[13:12] == 2'b11) begin
					if (addr == cfg.prog_addr) begin
						if (st.mode == irsc_pkg::MODE_WAIT) begin
							st_next.arena = cmd;
							flags.persist = 1'b1;
							flags.blink   = irsc_pkg::BLINK_FAST;
						end
					end else if (addr == cfg.ss_addr) begin
						if (cmd == {st.arena[5:1], 1'b1}) begin
							if (st.mode == irsc_pkg::MODE_WAIT) begin
								st_next.mode  = irsc_pkg::MODE_FIGHT;
								flags.persist = 1'b1;
							end
						end else if (cmd == {st.arena[5:1], 1'b0}) begin
							if (st.mode == irsc_pkg::MODE_FIGHT) begin
								st_next.mode  = irsc_pkg::MODE_STOPPED;
								flags.persist = 1'b1;
								flags.blink   = irsc_pkg::BLINK_SLOW;
							end
						end
					end
				end
			end
			irsc_pkg::REQ_TICK: begin
				// Bit window: re-arm sampling at the end of the period
				if (st.window >= cfg.bit_period) begin
					st_next.window = '0;
					st_next.armed  = 1'b1;
				end else begin
					st_next.window = st.window + 16'd1;
				end
			end
			irsc_pkg::REQ_CTRL: begin
				if (st.mode == irsc_pkg::MODE_FIGHT) begin
					if (!item.kill_pin) begin
						st_next.mode  = irsc_pkg::MODE_STOPPED;
						flags.persist = 1'b1;
						flags.blink   = irsc_pkg::BLINK_SLOW;
					end
					// Sensor priority, side sensors first
					if (sl) begin
						st_next.turn_left = 1'b1;
						st_next.held_l    = irsc_pkg::SPD_ZERO;
						st_next.held_r    = irsc_pkg::SPD_FULL;
					end else if (sr) begin
						st_next.turn_left = 1'b0;
						st_next.held_l    = irsc_pkg::SPD_FULL;
						st_next.held_r    = irsc_pkg::SPD_ZERO;
					end else if (fl && fr) begin
						st_next.held_l = ctr ? irsc_pkg::SPD_60 : irsc_pkg::SPD_FULL;
						st_next.held_r = ctr ? irsc_pkg::SPD_60 : irsc_pkg::SPD_FULL;
					end else if (fl) begin
						st_next.held_l = irsc_pkg::SPD_40;
						st_next.held_r = ctr ? irsc_pkg::SPD_60 : irsc_pkg::SPD_80;
					end else if (fr) begin
						st_next.held_l = ctr ? irsc_pkg::SPD_60 : irsc_pkg::SPD_80;
						st_next.held_r = irsc_pkg::SPD_40;
					end else if (st.turn_left) begin
						st_next.held_l = irsc_pkg::SPD_ZERO;
						st_next.held_r = irsc_pkg::SPD_FULL;
					end else begin
						st_next.held_l = irsc_pkg::SPD_FULL;
						st_next.held_r = irsc_pkg::SPD_ZERO;
					end
				end else begin
					st_next.held_l = irsc_pkg::SPD_ZERO;
					st_next.held_r = irsc_pkg::SPD_ZERO;
				end
			end
			default: begin
				// unknown request: state unchanged
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/ir_start_module_sumo_controller_top.sv
// Each accepted request beat is registered into stage 1, then scaled into the stage 2
// output register, which presents the result beat.
// Throughput: one request beat per cycle while the output is not stalled; state updates in the accept cycle,
// the next stage scales the held speeds by motor_scale (7x10 multiplier).
// Backpressure stalls both stages; an empty input stage still fills while a result waits.
// Reset (arst_n low, asynchronous) loads register defaults and the idle state.
`default_nettype none

`include "ir_start_module_sumo_controller_top_macros.svh"

module ir_start_module_sumo_controller_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	irsc_item_if.sink                                   item,
	irsc_result_if.source                               result,
	input  wire logic                                   cfg_we,
	input  wire logic [irsc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [irsc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

	irsc_pkg::cfg_t        cfg_q;
	irsc_pkg::state_t      st_q;
	irsc_pkg::state_t      st_next;
	irsc_pkg::step_flags_t flags;
	irsc_pkg::item_t       item_in;
	irsc_pkg::stage1_t     res_s1;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  ready_s1;
	logic                  ready_s2;
	logic                  in_acc;
	logic [15:0]           left_duty_s2;
	logic [15:0]           right_duty_s2;
	logic [1:0]            mode_s2;
	logic [5:0]            arena_s2;
	logic [1:0]            blink_s2;
	logic                  persist_s2;
	logic [13:0]           frame_s2;

	// Handshake
	assign ready_s2   = !valid_s2 || result.ready;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign item.ready = ready_s1;
	assign in_acc     = item.valid && ready_s1;

	assign item_in = '{
		req_type: item.req_type,
		ir_level: item.ir_level,
		kill_pin: item.kill_pin,
		eyes:     item.eyes
	};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= irsc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				irsc_pkg::CFG_BIT_PERIOD:  cfg_q.bit_period  <= cfg_wdata;
				irsc_pkg::CFG_EARLY_LIMIT: cfg_q.early_limit <= cfg_wdata;
				irsc_pkg::CFG_PROG_ADDR:   cfg_q.prog_addr   <= cfg_wdata[4:0];
				irsc_pkg::CFG_SS_ADDR:     cfg_q.ss_addr     <= cfg_wdata[4:0];
				irsc_pkg::CFG_MOTOR_SCALE: cfg_q.motor_scale <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	irsc_step u_step (
		.item    (item_in),
		.st      (st_q),
		.cfg     (cfg_q),
		.st_next (st_next),
		.flags   (flags)
	);

	// Controller state, updated once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= irsc_pkg::STATE_RESET;
		end else if (in_acc) begin
			st_q <= st_next;
		end
	end

	// Stage 1: post-step snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_s1 <= '{
				spd_l:   st_next.held_l,
				spd_r:   st_next.held_r,
				mode:    st_next.mode,
				arena:   st_next.arena,
				blink:   flags.blink,
				persist: flags.persist,
				frame:   st_next.frame
			};
		end
	end

	// Stage 2: duty scaling into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			left_duty_s2  <= irsc_pkg::duty_of(res_s1.spd_l, cfg_q.motor_scale);
			right_duty_s2 <= irsc_pkg::duty_of(res_s1.spd_r, cfg_q.motor_scale);
			mode_s2       <= res_s1.mode;
			arena_s2      <= res_s1.arena;
			blink_s2      <= res_s1.blink;
			persist_s2    <= res_s1.persist;
			frame_s2      <= res_s1.frame;
		end
	end

	assign result.valid         = valid_s2;
	assign result.left_duty     = left_duty_s2;
	assign result.right_duty    = right_duty_s2;
	assign result.mode          = mode_s2;
	assign result.arena_code    = arena_s2;
	assign result.blink_request = blink_s2;
	assign result.persist_write = persist_s2;
	assign result.frame_bits    = frame_s2;

	// Checks
	`IRSC_ASSERT_NEXT(a_stopped_sticks, st_q.mode == irsc_pkg::MODE_STOPPED,
		st_q.mode == irsc_pkg::MODE_STOPPED, "stopped mode left")
	`IRSC_ASSERT(a_arena_only_waiting,
		!$stable(st_q.arena) |-> $past(st_q.mode) == irsc_pkg::MODE_WAIT,
		"arena code changed outside waiting mode")
	`IRSC_ASSERT(a_no_drive_waiting,
		(st_q.held_l != irsc_pkg::SPD_ZERO || st_q.held_r != irsc_pkg::SPD_ZERO)
		|-> st_q.mode != irsc_pkg::MODE_WAIT, "motors driven while waiting")
	`IRSC_ASSERT(a_slow_blink_stopped,
		(valid_s2 && blink_s2 == irsc_pkg::BLINK_SLOW) |-> mode_s2 == irsc_pkg::MODE_STOPPED,
		"stop blink without stopped mode")

endmodule

`default_nettype wire

>>> dv/ir_start_module_sumo_controller_top_tb.sv
// Self-checking testbench for the start module controller: RC5 decode, window timing, fight control.
module ir_start_module_sumo_controller_top_tb;
	import irsc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	irsc_item_if   item_ch();
	irsc_result_if result_ch();

	ir_start_module_sumo_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// One predicted result beat
	typedef struct packed {
		logic [15:0] left_duty;
		logic [15:0] right_duty;
		logic [1:0]  mode;
		logic [5:0]  arena_code;
		logic [1:0]  blink_request;
		logic        persist_write;
		logic [13:0] frame_bits;
	} drive_status_t;

	drive_status_t controller_outputs[$];
	drive_status_t want_beat;

	// Predicted controller state
	logic [13:0] shift_frame = '0;
	logic        armed       = 1'b1;
	logic [15:0] window_cnt  = '0;
	logic [1:0]  run_mode    = MODE_WAIT;
	logic [5:0]  arena       = '0;
	logic        spin_left   = 1'b0;
	logic [6:0]  speed_l     = SPD_ZERO;
	logic [6:0]  speed_r     = SPD_ZERO;

	// Register copy
	logic [15:0] cfg_bit_period  = 16'd40421;
	logic [15:0] cfg_early_limit = 16'd10042;
	logic [4:0]  cfg_prog_addr   = 5'h0B;
	logic [4:0]  cfg_ss_addr     = 5'h07;
	logic [9:0]  cfg_scale       = 10'd640;

	int fail_count    = 0;
	int beats_sent    = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles  = 0;

	always #10 clk = ~clk;

	function automatic logic [15:0] scaled_duty(input logic [6:0] spd);
		int unsigned prod;
		prod = 32'(spd) * 32'(cfg_scale);
		return (prod > 32'hFFFF) ? 16'hFFFF : 16'(prod);
	endfunction

	function automatic void set_speeds(input logic [6:0] l, input logic [6:0] r);
		speed_l = l;
		speed_r = r;
	endfunction

	function automatic logic [13:0] rc5_word(input logic toggle, input logic [4:0] addr,
		input logic [5:0] cmd);
		return {2'b11, toggle, addr, cmd};
	endfunction

	// Never drop the kill pin while fighting, except in the kill test
	function automatic logic safe_kill();
		return (run_mode == MODE_FIGHT) ? 1'b1 : logic'($urandom_range(1));
	endfunction

	// Advance the predicted state by one accepted beat and queue its result
	function automatic void decode_and_drive(input logic [1:0] req, input logic lvl,
		input logic kill, input logic [4:0] eyes);
		logic [1:0]    blink;
		logic          persist;
		logic [4:0]    addr;
		logic [5:0]    cmd;
		drive_status_t beat;
		blink = BLINK_NONE;
		persist = 1'b0;
		case (req)
			REQ_EDGE: begin
				if (armed) begin
					armed = 1'b0;
					window_cnt = '0;
					shift_frame = {shift_frame[12:0], ~lvl};
				end else if (window_cnt < cfg_early_limit) begin
					shift_frame = '0;
				end
				// decode a frame with both start bits set
				if (run_mode != MODE_STOPPED && shift_frame[13:12] == 2'b11) begin
					addr = shift_frame[10:6];
					cmd = shift_frame[5:0];
					if (addr == cfg_prog_addr) begin
						if (run_mode == MODE_WAIT) begin
							arena = cmd;
							persist = 1'b1;
							blink = BLINK_FAST;
						end
					end else if (addr == cfg_ss_addr) begin
						if (cmd == (arena | 6'd1)) begin
							if (run_mode == MODE_WAIT) begin
								run_mode = MODE_FIGHT;
								persist = 1'b1;
							end
						end else if (cmd == (arena & 6'h3E)) begin
							if (run_mode == MODE_FIGHT) begin
								run_mode = MODE_STOPPED;
								persist = 1'b1;
								blink = BLINK_SLOW;
							end
						end
					end
				end
			end
			REQ_TICK: begin
				if (window_cnt >= cfg_bit_period) begin
					window_cnt = '0;
					armed = 1'b1;
				end else begin
					window_cnt = window_cnt + 16'd1;
				end
			end
			REQ_CTRL: begin
				if (run_mode == MODE_FIGHT) begin
					if (!kill) begin
						run_mode = MODE_STOPPED;
						persist = 1'b1;
						blink = BLINK_SLOW;
					end
					// sensor priority: sides, both fronts, one front, remembered spin
					if (eyes[EYE_SL]) begin
						spin_left = 1'b1;
						set_speeds(SPD_ZERO, SPD_FULL);
					end else if (eyes[EYE_SR]) begin
						spin_left = 1'b0;
						set_speeds(SPD_FULL, SPD_ZERO);
					end else if (eyes[EYE_FL] && eyes[EYE_FR]) begin
						if (eyes[EYE_C]) set_speeds(SPD_60, SPD_60);
						else set_speeds(SPD_FULL, SPD_FULL);
					end else if (eyes[EYE_FL]) begin
						set_speeds(SPD_40, eyes[EYE_C] ? SPD_60 : SPD_80);
					end else if (eyes[EYE_FR]) begin
						set_speeds(eyes[EYE_C] ? SPD_60 : SPD_80, SPD_40);
					end else if (spin_left) begin
						set_speeds(SPD_ZERO, SPD_FULL);
					end else begin
						set_speeds(SPD_FULL, SPD_ZERO);
					end
				end else begin
					set_speeds(SPD_ZERO, SPD_ZERO);
				end
			end
			default: ;
		endcase
		beat.left_duty = scaled_duty(speed_l);
		beat.right_duty = scaled_duty(speed_r);
		beat.mode = run_mode;
		beat.arena_code = arena;
		beat.blink_request = blink;
		beat.persist_write = persist;
		beat.frame_bits = shift_frame;
		controller_outputs.push_back(beat);
	endfunction

	// Present one request beat and wait for it to be taken
	task automatic send_item(input logic [1:0] req, input logic lvl, input logic kill,
		input logic [4:0] eyes);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.req_type = req;
		item_ch.ir_level = lvl;
		item_ch.kill_pin = kill;
		item_ch.eyes = eyes;
		do @(posedge clk); while (!item_ch.ready);
		decode_and_drive(req, lvl, kill, eyes);
		beats_sent++;
		@(negedge clk);
	endtask

	// Shift a 14-bit frame in, msb first, ticking the window between bits
	task automatic send_frame(input logic [13:0] bits);
		for (int i = 13; i >= 0; i--) begin
			while (!armed) begin
				if ($urandom_range(3) == 0)
					send_item(REQ_CTRL, 1'($urandom_range(1)), safe_kill(),
						5'($urandom_range(31)));
				else
					send_item(REQ_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
						5'($urandom_range(31)));
			end
			send_item(REQ_EDGE, ~bits[i], 1'($urandom_range(1)), 5'($urandom_range(31)));
		end
	endtask

	task automatic settle_outputs();
		item_ch.valid = 1'b0;
		while (controller_outputs.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_BIT_PERIOD:  cfg_bit_period = val;
			CFG_EARLY_LIMIT: cfg_early_limit = val;
			CFG_PROG_ADDR:   cfg_prog_addr = val[4:0];
			CFG_SS_ADDR:     cfg_ss_addr = val[4:0];
			CFG_MOTOR_SCALE: cfg_scale = val[9:0];
			default: ;
		endcase
	endtask

	// All registers are rewritten only once the pipeline is empty
	task automatic set_config(input logic [15:0] bp, input logic [15:0] el,
		input logic [15:0] pa, input logic [15:0] sa, input logic [15:0] ms);
		settle_outputs();
		write_reg(CFG_BIT_PERIOD, bp);
		write_reg(CFG_EARLY_LIMIT, el);
		write_reg(CFG_PROG_ADDR, pa);
		write_reg(CFG_SS_ADDR, sa);
		write_reg(CFG_MOTOR_SCALE, ms);
	endtask

	task automatic randomize_config();
		logic [15:0] bp;
		logic [15:0] el;
		logic [15:0] pa;
		logic [15:0] sa;
		logic [15:0] ms;
		bp = ($urandom_range(9) < 8) ? 16'($urandom_range(3)) : 16'($urandom_range(4, 12));
		case ($urandom_range(3))
			0: el = 16'd0;
			1: el = 16'hFFFF;
			default: el = 16'($urandom_range(4));
		endcase
		// upper data bits of the address writes are junk now and then
		pa = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(31));
		sa = ($urandom_range(3) == 0) ? pa : 16'($urandom_range(31));
		case ($urandom_range(4))
			0: ms = 16'd0;
			1: ms = 16'd655;
			2: ms = 16'd1023;
			default: ms = 16'($urandom_range(1023));
		endcase
		set_config(bp, el, pa, sa, ms);
	endtask

	// Random frame, now and then with broken start bits; its command never starts or stops the fight
	task automatic send_random_frame();
		logic [4:0]  addr;
		logic [5:0]  cmd;
		logic [13:0] bits;
		case ($urandom_range(3))
			0: begin
				addr = cfg_prog_addr;
				cmd = 6'($urandom_range(63));
			end
			1, 2: begin
				addr = cfg_ss_addr;
				case ($urandom_range(2))
					0: cmd = arena | 6'd1;
					1: cmd = arena & 6'h3E;
					default: cmd = 6'($urandom_range(63));
				endcase
			end
			default: begin
				addr = 5'($urandom_range(31));
				cmd = 6'($urandom_range(63));
			end
		endcase
		if (addr == cfg_ss_addr && addr != cfg_prog_addr) begin
			if (run_mode == MODE_WAIT && cmd == (arena | 6'd1)) cmd = arena & 6'h3E;
			if (run_mode == MODE_FIGHT && cmd == (arena & 6'h3E)) cmd = arena | 6'd1;
		end
		bits = rc5_word(1'($urandom_range(1)), addr, cmd);
		// broken start bits now and then
		if ($urandom_range(9) == 0) bits[13:12] = 2'($urandom_range(3));
		send_frame(bits);
	endtask

	task automatic test_unknown_request();
		send_item(REQ_UNKNOWN, 1'b1, 1'b1, 5'h1F);
		// control tick while waiting: motors held at zero, kill ignored
		send_item(REQ_CTRL, 1'b0, 1'b0, 5'h1F);
		send_item(REQ_UNKNOWN, 1'b0, 1'b0, 5'h00);
	endtask

	task automatic test_sampling_window();
		send_item(REQ_EDGE, 1'b0, 1'b1, 5'h00);
		// unarmed edge well before the early limit
		send_item(REQ_EDGE, 1'b1, 1'b1, 5'h00);
		repeat (4) send_item(REQ_TICK, 1'b0, 1'b0, 5'h00);
		// window already past the new period: next tick re-arms
		set_config(16'd2, 16'd0, 16'h0B, 16'h07, 16'd640);
		send_item(REQ_TICK, 1'b1, 1'b0, 5'h00);
		send_item(REQ_EDGE, 1'b0, 1'b0, 5'h00);
		send_item(REQ_EDGE, 1'b1, 1'b0, 5'h00);
		set_config(16'hFFFF, 16'hFFFF, 16'h0B, 16'h07, 16'd640);
		send_item(REQ_EDGE, 1'b1, 1'b0, 5'h00);
		repeat (3) send_item(REQ_TICK, 1'b0, 1'b1, 5'h00);
	endtask

	task automatic test_arena_programming();
		set_config(16'd0, 16'd0, 16'd31, 16'd0, 16'd0);
		send_frame(rc5_word(1'b0, 5'd31, 6'h3F));
		send_frame(rc5_word(1'b1, 5'd31, 6'h2A));
		// program and start/stop share one address: programming wins
		set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_frame(rc5_word(1'b0, 5'd0, arena | 6'd1));
	endtask

	task automatic test_random_traffic(input int n_items);
		int first;
		int cfg_mark;
		int pick;
		first = beats_sent;
		cfg_mark = beats_sent;
		randomize_config();
		while (beats_sent - first < n_items) begin
			if (beats_sent - cfg_mark >= 120) begin
				randomize_config();
				cfg_mark = beats_sent;
			end
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_random_frame();
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 12))
					send_item(REQ_CTRL, 1'($urandom_range(1)), safe_kill(),
						5'($urandom_range(31)));
			end else begin
				repeat ($urandom_range(1, 6))
					send_item(2'($urandom_range(3)), 1'($urandom_range(1)), safe_kill(),
						5'($urandom_range(31)));
			end
		end
	endtask

	task automatic test_fight_start();
		set_config(16'd0, 16'd0, 16'h0B, 16'h07, 16'd640);
		send_frame(rc5_word(1'b0, 5'h0B, 6'h14));
		// stop command while waiting does nothing
		send_frame(rc5_word(1'b1, 5'h07, arena & 6'h3E));
		send_frame(rc5_word(1'b0, 5'h07, arena | 6'd1));
		// programming is locked once fighting
		send_frame(rc5_word(1'b1, 5'h0B, 6'h3F));
	endtask

	task automatic test_sensor_priority();
		set_config(16'd0, 16'd0, 16'h0B, 16'h07, 16'd655);
		for (int e = 0; e < 32; e++) send_item(REQ_CTRL, 1'b0, 1'b1, 5'(e));
		// remembered spin direction
		send_item(REQ_CTRL, 1'b1, 1'b1, 5'b00001);
		send_item(REQ_CTRL, 1'b1, 1'b1, 5'b00000);
		send_item(REQ_CTRL, 1'b1, 1'b1, 5'b10000);
		send_item(REQ_CTRL, 1'b1, 1'b1, 5'b00000);
		// a scale of 1023 saturates the duty at full speed
		set_config(16'd0, 16'd0, 16'h0B, 16'h07, 16'd1023);
		send_item(REQ_CTRL, 1'b0, 1'b1, 5'b00110);
		send_item(REQ_CTRL, 1'b0, 1'b1, 5'b01010);
		set_config(16'd0, 16'd0, 16'h0B, 16'h07, 16'd0);
		send_item(REQ_CTRL, 1'b0, 1'b1, 5'b01000);
	endtask

	task automatic test_kill_switch();
		set_config(16'd0, 16'd0, 16'h0B, 16'h07, 16'd640);
		// the kill tick still steers from the sensors
		send_item(REQ_CTRL, 1'b1, 1'b0, 5'($urandom_range(31)));
		send_item(REQ_CTRL, 1'b0, 1'b1, 5'($urandom_range(31)));
		// stopped for good: frames shift in but are ignored
		send_frame(rc5_word(1'b0, 5'h0B, 6'h21));
		send_frame(rc5_word(1'b1, 5'h07, arena | 6'd1));
		send_item(REQ_CTRL, 1'b1, 1'b1, 5'h1F);
	endtask

	task automatic check_field(input string name, input logic [15:0] want_v,
		input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
			fail_count++;
		end
	endtask

	// Result side stalls at random
	always @(negedge clk) begin
		result_ch.ready = arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (controller_outputs.size() == 0) begin
				$display("%0t: result beat with none expected, expected nothing, actual frame %0h",
					$time, result_ch.frame_bits);
				fail_count++;
			end else begin
				want_beat = controller_outputs.pop_front();
				check_field("left_duty", want_beat.left_duty, result_ch.left_duty);
				check_field("right_duty", want_beat.right_duty, result_ch.right_duty);
				check_field("mode", 16'(want_beat.mode), 16'(result_ch.mode));
				check_field("arena_code", 16'(want_beat.arena_code),
					16'(result_ch.arena_code));
				check_field("blink_request", 16'(want_beat.blink_request),
					16'(result_ch.blink_request));
				check_field("persist_write", 16'(want_beat.persist_write),
					16'(result_ch.persist_write));
				check_field("frame_bits", 16'(want_beat.frame_bits),
					16'(result_ch.frame_bits));
			end
		end
	end

	// Watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL ir_start_module_sumo_controller_top");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.req_type = REQ_EDGE;
		item_ch.ir_level = 1'b0;
		item_ch.kill_pin = 1'b0;
		item_ch.eyes = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 22;
		recv_idle_pct = 66;
		test_unknown_request();
		test_sampling_window();
		test_arena_programming();
		test_random_traffic(230);
		test_fight_start();
		test_sensor_priority();

		send_idle_pct = 66;
		recv_idle_pct = 22;
		test_random_traffic(230);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(230);
		test_kill_switch();

		item_ch.valid = 1'b0;
		while (controller_outputs.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
		if (fail_count == 0)
			$display("PASS ir_start_module_sumo_controller_top");
		else
			$display("FAIL ir_start_module_sumo_controller_top");
		$finish;
	end

endmodule
